FILE: sv/uer_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// uer_pkg - shared types and constants of the echo ranger
// Phase and controller encodings, register map, config and control structs.
// ----------------------------------------------------------------------------
package uer_pkg;

	// sizing
	localparam int MAX_TRIES  = 8;
	localparam int WIDTH_BITS = 17;
	localparam int TICK_W     = 17;
	localparam int SUM_W      = 20;
	localparam int DIST_W     = 20;
	localparam int VT_W       = 4;
	localparam int TIDX_W     = $clog2(MAX_TRIES + 1);
	localparam int FRAC_W     = 8;
	localparam int DVD_W      = SUM_W + FRAC_W;
	localparam int DEN_W      = VT_W + 8;
	localparam int CNT_W      = $clog2(DVD_W);
	localparam int ADD_W      = ((WIDTH_BITS > SUM_W) ? WIDTH_BITS : SUM_W) + 1;
	localparam int IN_W       = 8;
	localparam int OUT_W      = 24;
	localparam int ADDR_W     = 5;
	localparam int DATA_W     = 32;

	// register indexes (byte address = 4 * index)
	localparam logic [2:0] REG_TRY_COUNT = 3'd0;
	localparam logic [2:0] REG_MIN_VALID = 3'd1;
	localparam logic [2:0] REG_TIMEOUT   = 3'd2;
	localparam logic [2:0] REG_US_PER_CM = 3'd3;
	localparam logic [2:0] REG_SETTLE    = 3'd4;
	localparam logic [2:0] REG_TRIG_W    = 3'd5;

	// reset values
	localparam logic [3:0]  RST_TRY_COUNT = 4'd5;
	localparam logic [3:0]  RST_MIN_VALID = 4'd3;
	localparam logic [16:0] RST_TIMEOUT   = 17'd90000;
	localparam logic [7:0]  RST_US_PER_CM = 8'd58;
	localparam logic [15:0] RST_SETTLE    = 16'd10000;
	localparam logic [7:0]  RST_TRIG_W    = 8'd15;

	localparam logic [VT_W-1:0] MIN_NEED = VT_W'(3);

	typedef enum logic [2:0] {
		PH_IDLE    = 3'd0,
		PH_SETTLE  = 3'd1,
		PH_TRIG    = 3'd2,
		PH_WAIT    = 3'd3,
		PH_MEASURE = 3'd4
	} phase_t;

	typedef enum logic [1:0] {
		ST_RUN  = 2'd0,
		ST_DIV  = 2'd1,
		ST_PUSH = 2'd2
	} ctrl_state_t;

	typedef struct packed {
		logic [3:0]  try_count;
		logic [3:0]  min_valid;
		logic [16:0] echo_timeout_us;
		logic [7:0]  us_per_cm;
		logic [15:0] settle_us;
		logic [7:0]  trig_width_us;
	} cfg_t;

	// controller -> datapath
	typedef struct packed {
		logic step_en;
		logic div_start;
		logic div_en;
		logic load_step;
		logic load_div;
	} ctrl_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic need_div;
		logic div_last;
	} dp_stat_t;

endpackage : uer_pkg
`default_nettype wire

FILE: sv/ultrasonic_echo_ranger_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ultrasonic_echo_ranger_core - ultrasonic time-of-flight ranger
// Burst of trigger tries, echo width capture, trimmed-mean distance in Q8 cm.
//
//   channel  dir  word                                       handshake
//   s_*      in   one microsecond tick: start_req, echo      tvalid/tready
//   m_*      out  one result per tick: trig .. distance_q8   tvalid/tready
//   apb      in   six config registers at 4*index            psel/penable
//
// An ordinary tick is taken and its result is registered at once.
// The tick that ends a burst with enough valid tries starts the 28-bit
// restoring divider, which gives one quotient bit per cycle.
// Reset clears burst state and loads register defaults; no clearing pass.
// A stalled result blocks the next tick only while the result register is full.
// ----------------------------------------------------------------------------
module ultrasonic_echo_ranger_core
	import uer_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [DATA_W-1:0] pwdata,
	output logic      [DATA_W-1:0] prdata,
	output logic                   pready,
	input  wire logic              s_tvalid,
	output logic                   s_tready,
	input  wire logic [IN_W-1:0]   s_tdata,  // [0] start_req, [1] echo, [7:2] zero
	output logic                   m_tvalid,
	input  wire logic              m_tready,
	output logic      [OUT_W-1:0]  m_tdata   // [0] trig, [1] busy_res, [2] done_res,
	                                         // [3] status, [23:4] distance_q8
);

	cfg_t      cfg;
	ctrl_cmd_t cmd;
	dp_stat_t  stat;

	uer_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	uer_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	uer_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.start_req (s_tdata[0]),
		.echo      (s_tdata[1]),
		.cmd       (cmd),
		.stat      (stat),
		.result    (m_tdata)
	);

	// a tick is only taken when the result register has room
	a_room: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |-> !m_tvalid || m_tready)
		else $error("tick accepted with result register full");

	// no ticks taken while the divider runs
	a_div_hold: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_en |-> !s_tready)
		else $error("input ready during division");

	// the burst-end word never reports busy
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tdata[1] && m_tdata[2]))
		else $error("done and busy together");

	// off the done tick, status and distance are zero
	a_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[2] |-> m_tdata[23:3] == '0)
		else $error("result fields set off the done tick");

	// too few tries gives no distance
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[3] |-> m_tdata[23:4] == '0)
		else $error("distance with failed status");

endmodule : ultrasonic_echo_ranger_core
`default_nettype wire

FILE: sv/uer_regs.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// uer_regs - configuration register file
// APB-style write/read of the six ranging registers, zero wait states.
// ----------------------------------------------------------------------------
module uer_regs
	import uer_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [DATA_W-1:0] pwdata,
	output logic      [DATA_W-1:0] prdata,
	output logic                   pready,
	output cfg_t                   cfg
);

	cfg_t       cfg_q;
	logic       wr_en;
	logic [2:0] idx;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite & pready;
	assign idx    = paddr[4:2];
	assign cfg    = cfg_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.try_count       <= RST_TRY_COUNT;
			cfg_q.min_valid       <= RST_MIN_VALID;
			cfg_q.echo_timeout_us <= RST_TIMEOUT;
			cfg_q.us_per_cm       <= RST_US_PER_CM;
			cfg_q.settle_us       <= RST_SETTLE;
			cfg_q.trig_width_us   <= RST_TRIG_W;
		end else if (wr_en) begin
			case (idx)
				REG_TRY_COUNT: cfg_q.try_count       <= pwdata[3:0];
				REG_MIN_VALID: cfg_q.min_valid       <= pwdata[3:0];
				REG_TIMEOUT:   cfg_q.echo_timeout_us <= pwdata[16:0];
				REG_US_PER_CM: cfg_q.us_per_cm       <= pwdata[7:0];
				REG_SETTLE:    cfg_q.settle_us       <= pwdata[15:0];
				REG_TRIG_W:    cfg_q.trig_width_us   <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	// read mux
	always_comb begin
		case (idx)
			REG_TRY_COUNT: prdata = DATA_W'(cfg_q.try_count);
			REG_MIN_VALID: prdata = DATA_W'(cfg_q.min_valid);
			REG_TIMEOUT:   prdata = DATA_W'(cfg_q.echo_timeout_us);
			REG_US_PER_CM: prdata = DATA_W'(cfg_q.us_per_cm);
			REG_SETTLE:    prdata = DATA_W'(cfg_q.settle_us);
			REG_TRIG_W:    prdata = DATA_W'(cfg_q.trig_width_us);
			default:       prdata = '0;
		endcase
	end

endmodule : uer_regs
`default_nettype wire

FILE: sv/uer_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// uer_dp - ranging datapath
// Per-tick try sequencing and statistics, bit-serial divider, result register.
// ----------------------------------------------------------------------------
module uer_dp
	import uer_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire cfg_t             cfg,
	input  wire logic             start_req,
	input  wire logic             echo,
	input  wire ctrl_cmd_t        cmd,
	output dp_stat_t              stat,
	output logic      [OUT_W-1:0] result
);

	localparam logic [WIDTH_BITS-1:0] W_ONES = {WIDTH_BITS{1'b1}};
	localparam logic [SUM_W-1:0]      S_ONES = {SUM_W{1'b1}};
	localparam logic [DIST_W-1:0]     D_ONES = {DIST_W{1'b1}};
	localparam logic [VT_W-1:0]       VT_ONES = {VT_W{1'b1}};

	// burst state
	phase_t                phase_q;
	logic [TICK_W-1:0]     tick_q;
	logic [WIDTH_BITS-1:0] ew_q;
	logic [TIDX_W-1:0]     tidx_q;
	logic [VT_W-1:0]       vt_q;
	logic [SUM_W-1:0]      sum_q;
	logic [WIDTH_BITS-1:0] mn_q;
	logic [WIDTH_BITS-1:0] mx_q;

	// next state of one tick
	phase_t                ph_n;
	logic [TICK_W-1:0]     tick_n;
	logic [WIDTH_BITS-1:0] ew_n;
	logic [TIDX_W-1:0]     tidx_n;
	logic [VT_W-1:0]       vt_n;
	logic [SUM_W-1:0]      sum_n;
	logic [WIDTH_BITS-1:0] mn_n;
	logic [WIDTH_BITS-1:0] mx_n;
	logic                  trig_n;
	logic                  fin_n;

	logic [TIDX_W-1:0]     limit;
	logic [VT_W-1:0]       need;
	logic                  enough;
	logic [ADD_W-1:0]      edges;
	logic [SUM_W-1:0]      trimmed;
	logic [7:0]            upc;
	logic [DEN_W-1:0]      den;

	// divider
	logic [DVD_W-1:0]      dvd_q;
	logic [DEN_W-1:0]      den_q;
	logic [DEN_W-1:0]      rem_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [DEN_W:0]        rem_sh;
	logic                  q_bit;

	logic [OUT_W-1:0]      out_q;

	assign limit = (32'(cfg.try_count) > MAX_TRIES) ? TIDX_W'(MAX_TRIES)
	                                                : TIDX_W'(cfg.try_count);

	// one microsecond tick of the try sequencer
	always_comb begin
		logic try_end;
		logic ok;
		logic [ADD_W-1:0] acc;
		try_end = 1'b0;
		ok      = 1'b0;
		acc     = '0;
		ph_n    = phase_q;
		tick_n  = tick_q;
		ew_n    = ew_q;
		tidx_n  = tidx_q;
		vt_n    = vt_q;
		sum_n   = sum_q;
		mn_n    = mn_q;
		mx_n    = mx_q;
		trig_n  = 1'b0;
		fin_n   = 1'b0;

		if (ph_n == PH_IDLE && start_req) begin
			tick_n = '0;
			ew_n   = '0;
			tidx_n = '0;
			vt_n   = '0;
			sum_n  = '0;
			mn_n   = W_ONES;
			mx_n   = '0;
			ph_n   = PH_SETTLE;
		end
		if (ph_n == PH_SETTLE) begin
			if (tick_n < TICK_W'(cfg.settle_us)) begin
				tick_n = tick_n + 1'b1;
			end else begin
				ph_n   = PH_TRIG;
				tick_n = '0;
			end
		end
		if (ph_n == PH_TRIG) begin
			if (tick_n < TICK_W'(cfg.trig_width_us)) begin
				trig_n = 1'b1;
				tick_n = tick_n + 1'b1;
			end else begin
				ph_n   = PH_WAIT;
				tick_n = '0;
				ew_n   = '0;
			end
		end
		if (ph_n == PH_WAIT) begin
			tick_n = tick_n + 1'b1;
			if (echo) begin
				ph_n = PH_MEASURE;
				ew_n = WIDTH_BITS'(1);
			end
		end else if (ph_n == PH_MEASURE) begin
			if (echo) begin
				tick_n = tick_n + 1'b1;
				if (ew_n != W_ONES)
					ew_n = ew_n + 1'b1;
			end else begin
				try_end = 1'b1;
				ok      = 1'b1;
			end
		end
		// timeout covers waiting and measuring together
		if (!try_end && (ph_n == PH_WAIT || ph_n == PH_MEASURE)
				&& tick_n >= cfg.echo_timeout_us)
			try_end = 1'b1;

		if (try_end) begin
			if (ok) begin
				if (vt_n != VT_ONES)
					vt_n = vt_n + 1'b1;
				acc   = ADD_W'(sum_n) + ADD_W'(ew_n);
				sum_n = (acc > ADD_W'(S_ONES)) ? S_ONES : acc[SUM_W-1:0];
				if (ew_n < mn_n)
					mn_n = ew_n;
				if (ew_n > mx_n)
					mx_n = ew_n;
			end
			tidx_n = tidx_n + 1'b1;
			tick_n = '0;
			if (tidx_n >= limit) begin
				ph_n  = PH_IDLE;
				fin_n = 1'b1;
			end else begin
				ph_n = PH_SETTLE;
			end
		end
	end

	// end-of-burst figures
	assign need    = (cfg.min_valid < MIN_NEED) ? MIN_NEED : cfg.min_valid;
	assign enough  = vt_n >= need;
	assign edges   = ADD_W'(mn_n) + ADD_W'(mx_n);
	assign trimmed = (ADD_W'(sum_n) >= edges) ? SUM_W'(ADD_W'(sum_n) - edges) : '0;
	assign upc     = (cfg.us_per_cm == 8'd0) ? 8'd1 : cfg.us_per_cm;
	assign den     = DEN_W'(vt_n - VT_W'(2)) * DEN_W'(upc);

	assign stat.need_div = fin_n & enough;
	assign stat.div_last = (cnt_q == '0);

	// burst state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			tick_q  <= '0;
			ew_q    <= '0;
			tidx_q  <= '0;
			vt_q    <= '0;
			sum_q   <= '0;
			mn_q    <= W_ONES;
			mx_q    <= '0;
		end else if (cmd.step_en) begin
			phase_q <= ph_n;
			tick_q  <= tick_n;
			ew_q    <= ew_n;
			tidx_q  <= tidx_n;
			vt_q    <= vt_n;
			sum_q   <= sum_n;
			mn_q    <= mn_n;
			mx_q    <= mx_n;
		end
	end

	// restoring divider, one quotient bit per cycle
	assign rem_sh = {rem_q, dvd_q[DVD_W-1]};
	assign q_bit  = rem_sh >= {1'b0, den_q};

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			dvd_q <= {trimmed, {FRAC_W{1'b0}}};
			den_q <= den;
			rem_q <= '0;
			cnt_q <= CNT_W'(DVD_W - 1);
		end else if (cmd.div_en) begin
			rem_q <= q_bit ? DEN_W'(rem_sh - {1'b0, den_q}) : rem_sh[DEN_W-1:0];
			dvd_q <= {dvd_q[DVD_W-2:0], q_bit};
			cnt_q <= cnt_q - 1'b1;
		end
	end

	// result word: trig, busy, done, status, dist from bit 0 up
	always_ff @(posedge clk) begin
		if (cmd.load_step) begin
			out_q <= {{DIST_W{1'b0}}, fin_n & ~enough, fin_n, ph_n != PH_IDLE, trig_n};
		end else if (cmd.load_div) begin
			out_q <= {((|dvd_q[DVD_W-1:DIST_W]) ? D_ONES : dvd_q[DIST_W-1:0]),
			          1'b0, 1'b1, 1'b0, 1'b0};
		end
	end

	assign result = out_q;

endmodule : uer_dp
`default_nettype wire

FILE: sv/uer_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// uer_ctrl - ranging controller
// Stream handshakes, divider sequencing and result register occupancy.
// ----------------------------------------------------------------------------
module uer_ctrl
	import uer_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     s_tvalid,
	output logic          s_tready,
	output logic          m_tvalid,
	input  wire logic     m_tready,
	input  wire dp_stat_t stat,
	output ctrl_cmd_t     cmd
);

	ctrl_state_t state_q;
	ctrl_state_t state_n;
	logic        full_q;
	logic        out_free;

	assign out_free = ~full_q | m_tready;
	assign m_tvalid = full_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_RUN;
			full_q  <= 1'b0;
		end else begin
			state_q <= state_n;
			if (cmd.load_step | cmd.load_div)
				full_q <= 1'b1;
			else if (m_tready)
				full_q <= 1'b0;
		end
	end

	// next state and commands
	always_comb begin
		state_n  = state_q;
		cmd      = '0;
		s_tready = 1'b0;
		case (state_q)
			ST_RUN: begin
				s_tready = out_free;
				if (s_tvalid && out_free) begin
					cmd.step_en = 1'b1;
					if (stat.need_div) begin
						cmd.div_start = 1'b1;
						state_n       = ST_DIV;
					end else begin
						cmd.load_step = 1'b1;
					end
				end
			end
			ST_DIV: begin
				cmd.div_en = 1'b1;
				if (stat.div_last)
					state_n = ST_PUSH;
			end
			ST_PUSH: begin
				if (out_free) begin
					cmd.load_div = 1'b1;
					state_n      = ST_RUN;
				end
			end
			default: state_n = ST_RUN;
		endcase
	end

endmodule : uer_ctrl
`default_nettype wire

FILE: tb/tb_ultrasonic_echo_ranger_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ultrasonic_echo_ranger_core - self-checking bench for the echo ranger
// Feeds microsecond tick words (start request plus sampled echo level) and
// checks every result word against a cycle-free model of the burst, try and
// trimmed-mean logic. Each phase reprograms the six registers over APB while
// the ranger is idle, then runs trigger bursts. Most bursts use echo pulses
// timed to the programmed settle and trigger lengths; some are random noise.
// Both stream sides take random gaps, with calm stretches in between.
// ----------------------------------------------------------------------------
module tb_ultrasonic_echo_ranger_core;
	import uer_pkg::*;

	localparam int RAND_ITEMS = 1850;
	localparam logic [WIDTH_BITS-1:0] ECHO_W_SAT = '1;
	localparam logic [SUM_W-1:0] SUM_SAT = '1;
	localparam logic [DIST_W-1:0] DIST_SAT = '1;

	typedef struct packed {
		logic echo;
		logic start;
	} tick_t;

	typedef struct packed {
		logic [DIST_W-1:0] distance;
		logic              status;
		logic              done;
		logic              busy;
		logic              trig;
	} range_res_t;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic              pready;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [IN_W-1:0]   s_tdata = '0;  // [0] start_req, [1] echo
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [OUT_W-1:0]  m_tdata;       // [0] trig, [1] busy_res, [2] done_res,
	                                  // [3] status, [23:4] distance_q8

	// model copy of the registers
	logic [3:0]            c_tries;
	logic [3:0]            c_need;
	logic [16:0]           c_tmo;
	logic [7:0]            c_us_cm;
	logic [15:0]           c_settle;
	logic [7:0]            c_trigw;

	// model copy of the burst state
	phase_t                ph;
	logic [TICK_W-1:0]     tick_cnt;
	logic [WIDTH_BITS-1:0] echo_w;
	logic [3:0]            try_idx;
	logic [VT_W-1:0]       vld_cnt;
	logic [SUM_W-1:0]      w_sum;
	logic [WIDTH_BITS-1:0] w_min;
	logic [WIDTH_BITS-1:0] w_max;

	tick_t      tick_q[$];
	tick_t      burst_plan[$];
	int         fixed_w[$];
	range_res_t exp_q[$];

	tick_t      cur_tick;
	range_res_t got_res, want_res, pred_res;
	logic       holding = 1'b0;
	logic       tick_fired = 1'b0;
	logic       res_fired = 1'b0;
	bit         in_calm, out_calm, sparse;
	int         in_gap, out_stall, in_count, out_count;
	int         n_pushed;
	int         err_cnt;

	ultrasonic_echo_ranger_core i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// gap or stall length for one word
	function automatic int draw_gap(input bit calm);
		if (calm)
			return 0;
		if (sparse)
			return ($urandom_range(0, 15) == 0) ? int'($urandom_range(0, 10)) : 0;
		return int'($urandom_range(0, 10));
	endfunction

	// close one try; on the last try form the trimmed-mean distance
	task automatic end_try(input logic ok, inout range_res_t r);
		logic [3:0]        lim;
		logic [VT_W-1:0]   need;
		logic [SUM_W:0]    acc;
		logic [SUM_W:0]    edges;
		logic [SUM_W-1:0]  trimmed;
		logic [7:0]        upc;
		logic [DEN_W-1:0]  den;
		logic [DVD_W-1:0]  quo;
		lim = (c_tries > MAX_TRIES) ? 4'(MAX_TRIES) : c_tries;
		if (ok) begin
			if (vld_cnt < 4'd15)
				vld_cnt++;
			acc = w_sum + echo_w;
			w_sum = acc[SUM_W] ? SUM_SAT : acc[SUM_W-1:0];
			if (echo_w < w_min)
				w_min = echo_w;
			if (echo_w > w_max)
				w_max = echo_w;
		end
		try_idx++;
		tick_cnt = '0;
		if (try_idx >= lim) begin
			need = (c_need < MIN_NEED) ? MIN_NEED : c_need;
			r.done = 1'b1;
			if (vld_cnt < need) begin
				r.status = 1'b1;
				r.distance = '0;
			end else begin
				edges = w_min + w_max;
				trimmed = (w_sum >= edges) ? w_sum - edges : '0;
				upc = (c_us_cm == 8'd0) ? 8'd1 : c_us_cm;
				den = DEN_W'(vld_cnt - 4'd2) * DEN_W'(upc);
				quo = {trimmed, 8'h00} / den;
				r.status = 1'b0;
				r.distance = (|quo[DVD_W-1:DIST_W]) ? DIST_SAT : quo[DIST_W-1:0];
			end
			ph = PH_IDLE;
		end else begin
			ph = PH_SETTLE;
		end
	endtask

	// one microsecond tick of the ranger
	task automatic predict_tick(input logic start, input logic echo, output range_res_t r);
		r = '0;
		if (ph == PH_IDLE && start) begin
			tick_cnt = '0;
			echo_w = '0;
			try_idx = '0;
			vld_cnt = '0;
			w_sum = '0;
			w_min = '1;
			w_max = '0;
			ph = PH_SETTLE;
		end
		if (ph == PH_SETTLE) begin
			if (tick_cnt < c_settle) begin
				tick_cnt++;
			end else begin
				ph = PH_TRIG;
				tick_cnt = '0;
			end
		end
		if (ph == PH_TRIG) begin
			if (tick_cnt < c_trigw) begin
				r.trig = 1'b1;
				tick_cnt++;
			end else begin
				ph = PH_WAIT;
				tick_cnt = '0;
				echo_w = '0;
			end
		end
		if (ph == PH_WAIT) begin
			tick_cnt++;
			if (echo) begin
				ph = PH_MEASURE;
				echo_w = 1;
			end
		end else if (ph == PH_MEASURE) begin
			if (echo) begin
				tick_cnt++;
				if (echo_w != ECHO_W_SAT)
					echo_w++;
			end else begin
				end_try(1'b1, r);
			end
		end
		if ((ph == PH_WAIT || ph == PH_MEASURE) && tick_cnt >= c_tmo)
			end_try(1'b0, r);
		r.busy = (ph != PH_IDLE);
	endtask

	task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			err_cnt++;
		end
	endtask

	// APB write: setup then access; mirror the register into the model
	task automatic cfg_write(input logic [2:0] idx, input logic [DATA_W-1:0] val);
		@(negedge clk);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = {idx, 2'b00};
		pwdata = val;
		@(negedge clk);
		penable = 1'b1;
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		case (idx)
			REG_TRY_COUNT: c_tries = val[3:0];
			REG_MIN_VALID: c_need = val[3:0];
			REG_TIMEOUT:   c_tmo = val[16:0];
			REG_US_PER_CM: c_us_cm = val[7:0];
			REG_SETTLE:    c_settle = val[15:0];
			REG_TRIG_W:    c_trigw = val[7:0];
			default: ;
		endcase
	endtask

	task automatic load_cfg(input int tries, input int need, input int tmo, input int upc,
			input int settle, input int trigw);
		cfg_write(REG_TRY_COUNT, tries);
		cfg_write(REG_MIN_VALID, need);
		cfg_write(REG_TIMEOUT, tmo);
		cfg_write(REG_US_PER_CM, upc);
		cfg_write(REG_SETTLE, settle);
		cfg_write(REG_TRIG_W, trigw);
	endtask

	task automatic push_tick(input logic start, input logic echo);
		tick_q.push_back(tick_t'({echo, start}));
		n_pushed++;
	endtask

	// block until every tick word is taken and every result word checked
	task automatic wait_drained();
		while (tick_q.size() != 0 || holding || exp_q.size() != 0)
			@(negedge clk);
	endtask

	// run the ranger back to idle with a toggling echo so tries end fast
	task automatic settle_idle();
		int k;
		k = 0;
		wait_drained();
		while (ph != PH_IDLE) begin
			push_tick(1'b0, k[0]);
			k++;
			wait_drained();
		end
	endtask

	// one try: settle and trigger ticks with random echo, then an echo pulse or a timeout
	task automatic plan_try();
		int d, w, n, k;
		if (fixed_w.size() != 0) begin
			d = 1;
			w = fixed_w.pop_front();
		end else begin
			d = $urandom_range(0, 6);
			w = $urandom_range(1, 12);
		end
		repeat (int'(c_settle) + int'(c_trigw))
			burst_plan.push_back(tick_t'({1'($urandom_range(0, 1)), 1'b0}));
		if (d + w < int'(c_tmo)) begin
			repeat (d) burst_plan.push_back(tick_t'(2'b00));
			repeat (w) burst_plan.push_back(tick_t'(2'b10));
			burst_plan.push_back(tick_t'(2'b00));
		end else begin
			n = (c_tmo == '0) ? 1 : int'(c_tmo);
			for (k = 0; k < n; k++)
				burst_plan.push_back(tick_t'({k >= d, 1'b0}));
		end
	endtask

	// one burst, timed to the current registers or pure noise
	task automatic plan_burst(input bit noise, input bit pause_mid);
		int lim, half;
		burst_plan.delete();
		if (noise) begin
			repeat ($urandom_range(4, 60))
				burst_plan.push_back(tick_t'({1'($urandom_range(0, 1)), 1'b0}));
		end else begin
			lim = (c_tries > MAX_TRIES) ? MAX_TRIES : ((c_tries == '0) ? 1 : int'(c_tries));
			repeat (lim) plan_try();
		end
		// first word starts the burst; later starts land while busy or on done
		foreach (burst_plan[k])
			burst_plan[k].start = (k == 0) ? 1'b1 : ($urandom_range(0, 3) == 0);
		half = burst_plan.size() / 2;
		foreach (burst_plan[k]) begin
			if (pause_mid && k == half)
				wait_drained();
			tick_q.push_back(burst_plan[k]);
			n_pushed++;
		end
		repeat ($urandom_range(0, 3)) push_tick(1'b0, 1'($urandom_range(0, 1)));
		if (noise)
			settle_idle();
	endtask

	// input side: hold each word through its gap, then until taken
	always @(negedge clk) begin
		if (holding && tick_fired)
			holding = 1'b0;
		if (!holding && tick_q.size() != 0) begin
			cur_tick = tick_q.pop_front();
			holding = 1'b1;
			if (in_count % 64 == 0)
				in_calm = ($urandom_range(0, 3) == 0);
			in_count++;
			in_gap = draw_gap(in_calm);
		end
		if (holding && in_gap == 0) begin
			s_tvalid <= 1'b1;
			s_tdata <= IN_W'({cur_tick.echo, cur_tick.start});
		end else begin
			s_tvalid <= 1'b0;
			if (holding)
				in_gap--;
		end
	end

	// output side: random stall after each result word
	always @(negedge clk) begin
		if (res_fired) begin
			if (out_count % 64 == 0)
				out_calm = ($urandom_range(0, 3) == 0);
			out_count++;
			out_stall = draw_gap(out_calm);
		end
		if (out_stall > 0) begin
			m_tready <= 1'b0;
			out_stall--;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// check result words, then predict for the tick word taken this edge
	always @(posedge clk) begin
		res_fired = m_tvalid && m_tready;
		tick_fired = s_tvalid && s_tready;
		if (res_fired) begin
			got_res = m_tdata;
			if (exp_q.size() == 0) begin
				$error("result word %h with no expectation pending", m_tdata);
				err_cnt++;
			end else begin
				want_res = exp_q.pop_front();
				check_field("trig", want_res.trig, got_res.trig);
				check_field("busy_res", want_res.busy, got_res.busy);
				check_field("done_res", want_res.done, got_res.done);
				check_field("status", want_res.status, got_res.status);
				check_field("distance_q8", want_res.distance, got_res.distance);
			end
		end
		if (tick_fired) begin
			predict_tick(s_tdata[0], s_tdata[1], pred_res);
			exp_q.push_back(pred_res);
		end
	end

	initial begin
		int rand_base;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		err_cnt = 0;
		n_pushed = 0;
		sparse = 1'b0;
		c_tries = RST_TRY_COUNT;
		c_need = RST_MIN_VALID;
		c_tmo = RST_TIMEOUT;
		c_us_cm = RST_US_PER_CM;
		c_settle = RST_SETTLE;
		c_trigw = RST_TRIG_W;
		ph = PH_IDLE;
		tick_cnt = '0;
		echo_w = '0;
		try_idx = '0;
		vld_cnt = '0;
		w_sum = '0;
		w_min = '1;
		w_max = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// idle ticks under reset defaults
		repeat (4) push_tick(1'b0, 1'($urandom_range(0, 1)));
		wait_drained();

		// no settle, no trigger pulse, zero us per cm; sender pauses mid-burst
		load_cfg(3, 3, 20, 0, 0, 0);
		plan_burst(1'b0, 1'b1);
		plan_burst(1'b0, 1'b0);
		settle_idle();

		// zero try count, zero min valid, zero timeout drops every try
		load_cfg(0, 0, 0, 255, 2, 1);
		plan_burst(1'b0, 1'b0);
		settle_idle();

		// try count above the maximum, need eight
		load_cfg(15, 8, 40, 255, 3, 2);
		plan_burst(1'b0, 1'b1);
		settle_idle();

		// min valid above the try count, widest trigger
		load_cfg(4, 12, 25, 100, 1, 255);
		plan_burst(1'b0, 1'b0);
		settle_idle();

		// distance saturates: trimmed width of 4096 at one us per cm
		sparse = 1'b1;
		load_cfg(3, 3, 131071, 1, 0, 1);
		fixed_w = {1, 4096, 4096};
		plan_burst(1'b0, 1'b0);
		settle_idle();

		// longest settle and timeout, single try
		load_cfg(0, 3, 131071, 58, 65535, 255);
		plan_burst(1'b0, 1'b0);
		settle_idle();
		sparse = 1'b0;

		// random settings and bursts
		rand_base = n_pushed;
		while (n_pushed - rand_base < RAND_ITEMS) begin
			load_cfg(($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(3, 8),
				($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(3, 8),
				($urandom_range(0, 7) == 0) ? $urandom_range(0, 131071) : $urandom_range(0, 30),
				$urandom_range(0, 255), $urandom_range(0, 8), $urandom_range(0, 4));
			repeat ($urandom_range(2, 6))
				plan_burst($urandom_range(0, 4) == 0, $urandom_range(0, 9) == 0);
			settle_idle();
		end

		settle_idle();
		repeat (40) @(posedge clk);
		if (err_cnt == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	// watchdog
	initial begin
		#(250_000_000);
		$display("DONE: errors detected");
		$finish;
	end

endmodule
